>>> src/bezier_curve_subdivision_defines.svh
// Assertion macros used by the Bezier subdivision controller.
`ifndef BEZIER_CURVE_SUBDIVISION_DEFINES_SVH
`define BEZIER_CURVE_SUBDIVISION_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcs assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcs assertion failed");

`endif

>>> src/bcs_pkg.sv
// Shared types and constants of the Bezier subdivision block.
package bcs_pkg;

  localparam int MAX_POINTS_DEF  = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int IDX_W           = 5;
  localparam int U_W             = 17;
  localparam logic [U_W-1:0] U_ONE   = 17'd65536;
  localparam logic [U_W-1:0] U_RESET = 17'd32768;
  localparam int RND_SHIFT       = 16;
  localparam int RND_HALF        = 32768;
  localparam int WAIT_W          = 2;
  localparam logic [WAIT_W-1:0] DRAIN_LAST = 2'd2;
  localparam logic [WAIT_W-1:0] FLUSH_LAST = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_DRAIN,
    ST_EMIT,
    ST_FLUSH
  } bcs_state_e;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic             rd_right;
    logic [IDX_W-1:0] addr;
    logic             first;
    logic             last_rd;
    logic [IDX_W-1:0] idx;
    logic             last_res;
    logic             ovf;
  } bcs_cmd_t;

endpackage

>>> src/bcs_datapath.sv
// Datapath: point stores, blend pipeline and result register.
module bcs_datapath import bcs_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bcs_cmd_t                  cmd_i,
  input  logic signed [FIELD_W-1:0] point_x_i,
  input  logic signed [FIELD_W-1:0] point_y_i,
  input  logic                      cfg_we_i,
  input  logic [U_W-1:0]            cfg_wdata_i,
  output logic                      result_valid_o,
  output logic                      which_half_o,
  output logic [IDX_W-1:0]          point_index_o,
  output logic signed [FIELD_W-1:0] out_x_o,
  output logic signed [FIELD_W-1:0] out_y_o,
  output logic                      overflowed_o,
  output logic                      last_result_o
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = COORD_WIDTH;
  localparam int WW = 2 * CW;
  localparam int DW = CW + 1;
  localparam int PW = DW + U_W + 1;
  localparam int RW = PW - RND_SHIFT;

  logic [WW-1:0] work_mem  [MAX_POINTS];
  logic [WW-1:0] right_mem [MAX_POINTS];
  logic [WW-1:0] work_rd_q, right_rd_q, prev_q;

  bcs_cmd_t cmd1_q;
  logic     v2_q, v3_q;
  logic [AW-1:0] waddr2_q, waddr3_q;
  logic signed [DW-1:0] diff2_q [2];
  logic signed [CW-1:0] a2_q    [2];
  logic signed [CW-1:0] a3_q    [2];
  logic signed [PW-1:0] prod3_q [2];
  logic [U_W-1:0] u_q;

  logic signed [DW-1:0] diff_d [2];
  logic signed [CW-1:0] a_d    [2];
  logic signed [PW-1:0] prod_d [2];
  logic signed [RW-1:0] rnd    [2];
  logic [WW-1:0] blend_w, load_w, emit_w;
  logic s1_work, s1_blend, s1_emit;

  logic                      res_valid_q, half_q, ovf_q, last_q;
  logic [IDX_W-1:0]          idx_q;
  logic signed [FIELD_W-1:0] x_q, y_q;

  assign s1_work  = cmd1_q.rd_en && !cmd1_q.rd_right;
  assign s1_blend = s1_work && !cmd1_q.first;
  assign s1_emit  = cmd1_q.rd_en && (cmd1_q.rd_right || cmd1_q.first);
  assign emit_w   = cmd1_q.rd_right ? right_rd_q : work_rd_q;
  assign load_w   = {CW'(point_x_i), CW'(point_y_i)};

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      a_d[c]    = $signed(prev_q[c*CW +: CW]);
      diff_d[c] = DW'($signed(work_rd_q[c*CW +: CW])) - DW'(a_d[c]);
      prod_d[c] = PW'(diff2_q[c]) * PW'($signed({1'b0, u_q}));
      rnd[c]    = RW'((prod3_q[c] + PW'(RND_HALF)) >>> RND_SHIFT);
      blend_w[c*CW +: CW] = CW'(RW'(a3_q[c]) + rnd[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd1_q      <= '0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      res_valid_q <= 1'b0;
      u_q         <= U_RESET;
    end else begin
      cmd1_q      <= cmd_i;
      v2_q        <= s1_blend;
      v3_q        <= v2_q;
      res_valid_q <= s1_emit;
      if (cfg_we_i) begin
        u_q <= (cfg_wdata_i > U_ONE) ? U_ONE : cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_mem[cmd_i.addr[AW-1:0]] <= load_w;
    end else if (v3_q) begin
      work_mem[waddr3_q] <= blend_w;
    end
    if (cmd_i.rd_en) begin
      work_rd_q  <= work_mem[cmd_i.addr[AW-1:0]];
      right_rd_q <= right_mem[cmd_i.addr[AW-1:0]];
    end
    if (s1_work && cmd1_q.last_rd) begin
      right_mem[cmd1_q.addr[AW-1:0]] <= work_rd_q;
    end
    if (s1_work) begin
      prev_q <= work_rd_q;
    end
    waddr2_q <= cmd1_q.addr[AW-1:0] - AW'(1);
    waddr3_q <= waddr2_q;
    for (int c = 0; c < 2; c++) begin
      diff2_q[c] <= diff_d[c];
      a2_q[c]    <= a_d[c];
      a3_q[c]    <= a2_q[c];
      prod3_q[c] <= prod_d[c];
    end
    half_q <= cmd1_q.rd_right;
    idx_q  <= cmd1_q.idx;
    ovf_q  <= cmd1_q.ovf;
    last_q <= cmd1_q.last_res;
    x_q    <= FIELD_W'(emit_w[CW +: CW]);
    y_q    <= FIELD_W'(emit_w[0 +: CW]);
  end

  assign result_valid_o = res_valid_q;
  assign which_half_o   = half_q;
  assign point_index_o  = idx_q;
  assign out_x_o        = x_q;
  assign out_y_o        = y_q;
  assign overflowed_o   = ovf_q;
  assign last_result_o  = last_q;

endmodule

>>> src/bcs_ctrl.sv
// Controller: point loading, subdivision rounds and result readout sequencing.
`include "bezier_curve_subdivision_defines.svh"

module bcs_ctrl import bcs_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     last_point_i,
  output logic     busy,
  output bcs_cmd_t cmd_o
);

  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);

  bcs_state_e state_q, state_d;
  logic [CNTW-1:0]   count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [AW-1:0]     r_q, r_d, k_q, k_d, top_w;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic              last_r;

  assign top_w  = AW'(count_q - CNTW'(1) - CNTW'(r_q));
  assign last_r = (r_q == AW'(count_q - CNTW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      r_q     <= '0;
      k_q     <= '0;
      wait_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      r_q     <= r_d;
      k_q     <= k_d;
      wait_q  <= wait_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    r_d       = r_q;
    k_d       = k_q;
    wait_d    = wait_q;
    cmd_o     = '0;
    cmd_o.ovf = ovf_q;
    busy      = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (count_q < CNTW'(MAX_POINTS)) begin
            cmd_o.load = 1'b1;
            cmd_o.addr = IDX_W'(count_q);
            count_d    = count_q + CNTW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_point_i) begin
            state_d = ST_ROUND;
            r_d     = '0;
            k_d     = '0;
          end
        end
      end
      ST_ROUND: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.addr    = IDX_W'(k_q);
        cmd_o.first   = (k_q == '0);
        cmd_o.last_rd = (k_q == top_w);
        cmd_o.idx     = IDX_W'(r_q);
        if (k_q == top_w) begin
          k_d     = '0;
          wait_d  = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (wait_q == DRAIN_LAST) begin
          if (last_r) begin
            r_d     = '0;
            state_d = ST_EMIT;
          end else begin
            r_d     = r_q + AW'(1);
            state_d = ST_ROUND;
          end
        end else begin
          wait_d = wait_q + WAIT_W'(1);
        end
      end
      ST_EMIT: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_right = 1'b1;
        cmd_o.addr     = IDX_W'(r_q);
        cmd_o.idx      = IDX_W'(r_q);
        cmd_o.last_res = last_r;
        if (last_r) begin
          wait_d  = '0;
          state_d = ST_FLUSH;
        end else begin
          r_d = r_q + AW'(1);
        end
      end
      ST_FLUSH: begin
        if (wait_q == FLUSH_LAST) begin
          state_d = ST_IDLE;
          count_d = '0;
          ovf_d   = 1'b0;
        end else begin
          wait_d = wait_q + WAIT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `BCS_ASSERT_IMP(a_count_le_max, 1'b1, count_q <= CNTW'(MAX_POINTS))
  `BCS_ASSERT_IMP(a_run_not_empty, state_q != ST_IDLE, count_q != '0)
  `BCS_ASSERT_IMP(a_round_k_le_top, state_q == ST_ROUND, k_q <= top_w)
  `BCS_ASSERT_NXT(a_flush_to_idle, state_q == ST_FLUSH && wait_q == FLUSH_LAST,
                  state_q == ST_IDLE && count_q == '0 && !ovf_q)

endmodule

>>> src/bezier_curve_subdivision.sv
// Top level of the de Casteljau Bezier subdivision block.
//
// Control points enter one item per cycle: an item is taken when start is
// high and busy is low. Points past MAX_POINTS are dropped and flag the run.
// The item with last_point_i set launches the subdivision at split_u, which
// is loaded through cfg_we_i and cfg_wdata_i; the user must load it only
// while the block is idle, which the block itself does not enforce.
// For a curve of n points, round r reads n-r stored points through one
// shared pair of multipliers and then waits in ST_DRAIN for the blend
// pipeline to drain. Left sub-curve points leave during the rounds, right
// sub-curve points leave afterwards, one per cycle, and busy falls once
// ST_FLUSH has followed the last readout. The first result is the first
// point read in round zero, passed through cmd1_q and the result register.
// Each result is valid for exactly one cycle on result_valid_o; the receiver
// cannot stall. Reset empties the point store, clears the overflow flag and
// sets split_u to one half.
module bezier_curve_subdivision import bcs_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [FIELD_W-1:0] point_x_i,
  input  logic signed [FIELD_W-1:0] point_y_i,
  input  logic                      last_point_i,
  input  logic                      cfg_we_i,
  input  logic [U_W-1:0]            cfg_wdata_i,
  output logic                      result_valid_o,
  output logic                      which_half_o,
  output logic [IDX_W-1:0]          point_index_o,
  output logic signed [FIELD_W-1:0] out_x_o,
  output logic signed [FIELD_W-1:0] out_y_o,
  output logic                      overflowed_o,
  output logic                      last_result_o
);

  bcs_cmd_t cmd;

  bcs_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .last_point_i (last_point_i),
    .busy         (busy),
    .cmd_o        (cmd)
  );

  bcs_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .which_half_o   (which_half_o),
    .point_index_o  (point_index_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .overflowed_o   (overflowed_o),
    .last_result_o  (last_result_o)
  );

endmodule
